>>> hw/rtl/usalu_pkg.sv
// ----------------------------------------------------------------------------
// usalu_pkg: shared types and opcodes for the 64-bit unsigned ALU
// Opcode names and the word carried between divider cells.
// ----------------------------------------------------------------------------
package usalu_pkg;

    localparam int unsigned DataW = 64;
    localparam int unsigned ModeW = 5;

    localparam logic [ModeW-1:0] OP_NOT   = 5'd0;
    localparam logic [ModeW-1:0] OP_NOTF  = 5'd1;
    localparam logic [ModeW-1:0] OP_ONES  = 5'd2;
    localparam logic [ModeW-1:0] OP_NEG   = 5'd3;
    localparam logic [ModeW-1:0] OP_EQ    = 5'd4;
    localparam logic [ModeW-1:0] OP_NE    = 5'd5;
    localparam logic [ModeW-1:0] OP_GT    = 5'd6;
    localparam logic [ModeW-1:0] OP_GE    = 5'd7;
    localparam logic [ModeW-1:0] OP_LT    = 5'd8;
    localparam logic [ModeW-1:0] OP_LE    = 5'd9;
    localparam logic [ModeW-1:0] OP_XOR   = 5'd10;
    localparam logic [ModeW-1:0] OP_BAND  = 5'd11;
    localparam logic [ModeW-1:0] OP_BOR   = 5'd12;
    localparam logic [ModeW-1:0] OP_SHR   = 5'd13;
    localparam logic [ModeW-1:0] OP_SHL   = 5'd14;
    localparam logic [ModeW-1:0] OP_LAND  = 5'd15;
    localparam logic [ModeW-1:0] OP_LOR   = 5'd16;
    localparam logic [ModeW-1:0] OP_ADD   = 5'd17;
    localparam logic [ModeW-1:0] OP_SUB   = 5'd18;
    localparam logic [ModeW-1:0] OP_MUL   = 5'd19;
    localparam logic [ModeW-1:0] OP_DIV   = 5'd20;
    localparam logic [ModeW-1:0] OP_MOD   = 5'd21;

    // word handed from one cell to the next
    typedef struct packed {
        logic             vld;
        logic [ModeW-1:0] mode;
        logic [DataW-1:0] a;     // left operand (dividend shifted in)
        logic [DataW-1:0] b;     // right operand / divisor
        logic [DataW-1:0] quo;   // quotient bits so far
        logic [DataW-1:0] rem;   // partial remainder
        logic [DataW-1:0] res;   // result for non-divide ops, or partial product
        logic [DataW-1:0] mhi;   // cross-term accumulator for multiply
    } cell_word_t;

endpackage

>>> hw/rtl/usalu_cell.sv
// ----------------------------------------------------------------------------
// usalu_cell: one cell of the ALU chain
// Retires DigW quotient bits per cycle while en is high (restoring), shifting
// as many bits out of a; every other field of the word rides through unchanged.
// ----------------------------------------------------------------------------
module usalu_cell #(
    parameter int unsigned DigW = 4
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  usalu_pkg::cell_word_t  word_in,
    output usalu_pkg::cell_word_t  word_out
);

    usalu_pkg::cell_word_t cell_reg, cell_next;

    always_comb begin
        logic [usalu_pkg::DataW:0] r;
        logic [usalu_pkg::DataW:0] t;
        cell_next = word_in;
        r = '0;
        t = '0;
        r[usalu_pkg::DataW-1:0] = word_in.rem;
        for (int i = 0; i < int'(DigW); i++) begin
            r = {r[usalu_pkg::DataW-1:0], cell_next.a[usalu_pkg::DataW-1]};
            cell_next.a = {cell_next.a[usalu_pkg::DataW-2:0], 1'b0};
            t = r - {1'b0, word_in.b};
            if (!t[usalu_pkg::DataW]) begin
                r = t;
                cell_next.quo = {cell_next.quo[usalu_pkg::DataW-2:0], 1'b1};
            end else begin
                cell_next.quo = {cell_next.quo[usalu_pkg::DataW-2:0], 1'b0};
            end
        end
        cell_next.rem = r[usalu_pkg::DataW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_reg.vld <= 1'b0;
        end else if (en) begin
            cell_reg <= cell_next;
        end
    end

    assign word_out = cell_reg;

endmodule

>>> hw/rtl/usalu_front.sv
// ----------------------------------------------------------------------------
// usalu_front: entry cell
// Computes every op but divide and modulo, and the 32x32 partial products of multiply.
// ----------------------------------------------------------------------------
module usalu_front (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               en,
    input  logic                               vld_in,
    input  logic [usalu_pkg::ModeW-1:0]        mode,
    input  logic [usalu_pkg::DataW-1:0]        a,
    input  logic [usalu_pkg::DataW-1:0]        b,
    output usalu_pkg::cell_word_t              word_out
);

    usalu_pkg::cell_word_t w_reg, w_next;
    logic [usalu_pkg::DataW-1:0] res;
    logic                        big_sh;

    assign big_sh = |b[usalu_pkg::DataW-1:6];

    always_comb begin
        unique case (mode)
            usalu_pkg::OP_NOT, usalu_pkg::OP_NOTF:
                res = {63'd0, a == '0};
            usalu_pkg::OP_ONES:  res = ~a;
            usalu_pkg::OP_NEG:   res = '0 - a;
            usalu_pkg::OP_EQ:    res = {63'd0, a == b};
            usalu_pkg::OP_NE:    res = {63'd0, a != b};
            usalu_pkg::OP_GT:    res = {63'd0, a > b};
            usalu_pkg::OP_GE:    res = {63'd0, a >= b};
            usalu_pkg::OP_LT:    res = {63'd0, a < b};
            usalu_pkg::OP_LE:    res = {63'd0, a <= b};
            usalu_pkg::OP_XOR:   res = a ^ b;
            usalu_pkg::OP_BAND:  res = a & b;
            usalu_pkg::OP_BOR:   res = a | b;
            usalu_pkg::OP_SHR:   res = big_sh ? '0 : a >> b[5:0];
            usalu_pkg::OP_SHL:   res = big_sh ? '0 : a << b[5:0];
            usalu_pkg::OP_LAND:  res = {63'd0, (a != '0) && (b != '0)};
            usalu_pkg::OP_LOR:   res = {63'd0, (a != '0) || (b != '0)};
            usalu_pkg::OP_ADD:   res = a + b;
            usalu_pkg::OP_SUB:   res = a - b;
            usalu_pkg::OP_MUL:   res = a[31:0] * b[31:0];
            default:             res = a;
        endcase
    end

    always_comb begin
        w_next      = '0;
        w_next.vld  = vld_in;
        w_next.mode = mode;
        w_next.a    = a;
        w_next.b    = b;
        w_next.res  = res;
        // low 32 bits of the cross terms; combined in the stage after the front cell
        w_next.mhi  = {32'd0, a[31:0] * b[63:32]};
        w_next.quo  = {32'd0, a[63:32] * b[31:0]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_reg.vld <= 1'b0;
        end else if (en) begin
            w_reg <= w_next;
        end
    end

    assign word_out = w_reg;

endmodule

>>> hw/rtl/unsigned_script_alu_top.sv
// ----------------------------------------------------------------------------
// unsigned_script_alu_top: pipelined 64-bit unsigned ALU
// Front cell, a multiply fold stage, a chain of divider cells, and an output register.
// ----------------------------------------------------------------------------
//  channel | ports                                          | dir
//  input   | s_valid s_ready s_mode s_left_operand          | in
//          | s_right_operand                                |
//  result  | m_valid m_ready m_result_value                 | out
//
//  One word accepted per cycle while the chain is not stalled; 2 + 64/DigW
//  register stages, and every op passes through all of them (other ops ride
//  along the divider chain with their result).
//  Multiply partial products are summed in the stage after the front cell.
//  The chain stalls as a whole when the output word is not taken; s_ready
//  is low only then. Reset clears the valid bits of every stage.
module unsigned_script_alu_top #(
    parameter int unsigned DigW = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [4:0]  s_mode,
    input  logic [63:0] s_left_operand,
    input  logic [63:0] s_right_operand,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_result_value
);

    localparam int unsigned NCell = usalu_pkg::DataW / DigW;

    usalu_pkg::cell_word_t chain [0:NCell];
    usalu_pkg::cell_word_t mid_reg;
    usalu_pkg::cell_word_t mid_next;
    logic                  en;
    logic                  out_vld_reg;
    logic [63:0]           out_reg;
    logic [63:0]           out_next;
    usalu_pkg::cell_word_t last;

    // whole chain advances unless the output word is held
    assign en      = !out_vld_reg || m_ready;
    assign s_ready = en;

    usalu_front u_front (
        .aclk(aclk), .aresetn(aresetn), .en(en), .vld_in(s_valid),
        .mode(s_mode), .a(s_left_operand), .b(s_right_operand),
        .word_out(chain[0])
    );

    // multiply: fold the cross terms into the upper half, clear divider fields
    always_comb begin
        mid_next     = chain[0];
        mid_next.quo = '0;
        mid_next.rem = '0;
        if (chain[0].mode == usalu_pkg::OP_MUL) begin
            mid_next.res = chain[0].res
                + {chain[0].mhi[31:0] + chain[0].quo[31:0], 32'd0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mid_reg.vld <= 1'b0;
        end else if (en) begin
            mid_reg <= mid_next;
        end
    end

    assign chain[1] = mid_reg;

    for (genvar g = 1; g < int'(NCell); g++) begin : g_cell
        usalu_cell #(.DigW(DigW)) u_cell (
            .aclk(aclk), .aresetn(aresetn), .en(en),
            .word_in(chain[g]), .word_out(chain[g+1])
        );
    end

    // last digit group done combinationally into the output register
    usalu_pkg::cell_word_t fin;
    always_comb begin
        logic [64:0] r;
        logic [64:0] t;
        last = chain[NCell];
        fin  = last;
        r    = {1'b0, last.rem};
        t    = '0;
        for (int i = 0; i < int'(DigW); i++) begin
            r = {r[63:0], fin.a[63]};
            fin.a = {fin.a[62:0], 1'b0};
            t = r - {1'b0, last.b};
            if (!t[64]) begin
                r = t;
                fin.quo = {fin.quo[62:0], 1'b1};
            end else begin
                fin.quo = {fin.quo[62:0], 1'b0};
            end
        end
        fin.rem = r[63:0];
        if (last.mode == usalu_pkg::OP_DIV) begin
            out_next = (last.b == '0) ? '0 : fin.quo;
        end else if (last.mode == usalu_pkg::OP_MOD) begin
            out_next = (last.b == '0) ? '0 : fin.rem;
        end else begin
            out_next = last.res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (en) begin
            out_vld_reg <= last.vld;
            out_reg     <= out_next;
        end
    end

    assign m_valid        = out_vld_reg;
    assign m_result_value = out_reg;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_value))
        else $error("result word changed while stalled");
    a_rdy: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input blocked with empty output");
    a_div0: assert property (@(posedge aclk) disable iff (!aresetn)
        en && last.vld && (last.mode == usalu_pkg::OP_DIV) && last.b == '0
        |=> m_result_value == '0)
        else $error("divide by zero not zero");

endmodule
